// ===== sv/hbp_pkg.sv =====
// Shared types, constants and character classes for the HTTP/1 header block parser.
// No dependencies; used by hbp_step and http_header_block_parser.
package hbp_pkg;

  localparam int unsigned PosW      = 16;
  localparam int unsigned LineW     = 8;
  localparam int unsigned OutDataW  = 80;

  localparam logic [PosW-1:0]  MaxBlockBytesRst  = 16'd16384;
  localparam logic [LineW-1:0] MaxHeaderCountRst = 8'd64;

  // config register indexes
  typedef enum logic [0:0] {
    REG_MAX_BLOCK_BYTES  = 1'b0,
    REG_MAX_HEADER_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [7:0] {
    PH_NAME   = 8'b0000_0001,
    PH_VSTART = 8'b0000_0010,
    PH_VALUE  = 8'b0000_0100,
    PH_CR     = 8'b0000_1000,
    PH_EOL    = 8'b0001_0000,
    PH_CR2    = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_ERR    = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYNTAX = 2'd1,
    ERR_LARGE  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_MORE     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2
  } status_e;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChDel   = 8'h7F;

  typedef struct packed {
    phase_e           phase;
    err_e             err;
    logic [PosW-1:0]  pos;
    logic [LineW-1:0] lines;
    logic [PosW-1:0]  name_off;
    logic [PosW-1:0]  name_cnt;
    logic [PosW-1:0]  val_off;
    logic [PosW-1:0]  val_cnt;
  } state_t;

  localparam state_t StateRst = '{
    phase: PH_NAME, err: ERR_NONE, pos: '0, lines: '0,
    name_off: '0, name_cnt: '0, val_off: '0, val_cnt: '0
  };

  // packed lowest field last so status lands in bit 0
  typedef struct packed {
    logic [PosW-1:0]  field_value_length;
    logic [PosW-1:0]  field_value_start;
    logic [PosW-1:0]  field_name_length;
    logic [PosW-1:0]  field_name_start;
    logic [LineW-1:0] record_index;
    logic             record_valid;
    logic             byte_ignored;
    err_e             error_kind;
    status_e          status;
  } result_t;

  function automatic logic tok_char(input logic [7:0] c);
    logic alnum;
    alnum = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h30 && c <= 8'h39);
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
      default: return alnum;
    endcase
  endfunction

  function automatic logic ctl_char(input logic [7:0] c);
    return (c < ChSp) || (c == ChDel);
  endfunction

endpackage

// ===== sv/hbp_step.sv =====
// Per-byte parser step: next parser state and the result for one byte.
// Depends on hbp_pkg.
module hbp_step (
  input  hbp_pkg::state_t  state_i,
  input  logic [7:0]       data_byte_i,
  input  logic             start_block_i,
  input  logic [15:0]      max_block_bytes_i,
  input  logic [7:0]       max_header_count_i,
  output hbp_pkg::state_t  state_o,
  output hbp_pkg::result_t result_o
);
  import hbp_pkg::*;

  state_t          cur;
  state_t          nxt;
  result_t         res;
  logic [PosW-1:0] here;
  logic [PosW:0]   here_inc;

  always_comb begin
    cur      = start_block_i ? StateRst : state_i;
    nxt      = cur;
    res      = '0;
    here     = cur.pos;
    here_inc = {1'b0, here} + {{PosW{1'b0}}, 1'b1};

    if (cur.phase == PH_DONE || cur.phase == PH_ERR) begin
      res.byte_ignored = 1'b1;
    end else if (here_inc > {1'b0, max_block_bytes_i}) begin
      nxt.phase = PH_ERR;
      nxt.err   = ERR_LARGE;
    end else begin
      nxt.pos = here_inc[PosW-1:0];
      unique case (cur.phase)
        PH_NAME: begin
          if (data_byte_i == ChColon) begin
            if (cur.name_cnt == '0) begin
              nxt.phase = PH_ERR;
              nxt.err   = ERR_SYNTAX;
            end else begin
              nxt.phase = PH_VSTART;
            end
          end else if (!tok_char(data_byte_i)) begin
            nxt.phase = PH_ERR;
            nxt.err   = ERR_SYNTAX;
          end else begin
            if (cur.name_cnt == '0) nxt.name_off = here;
            nxt.name_cnt = cur.name_cnt + 16'd1;
          end
        end
        PH_VSTART: begin
          if (data_byte_i == ChSp || data_byte_i == ChTab) begin
            // leading OWS dropped
          end else if (data_byte_i == ChCr) begin
            nxt.val_off = here;
            nxt.val_cnt = '0;
            nxt.phase   = PH_CR;
          end else if (ctl_char(data_byte_i)) begin
            nxt.phase = PH_ERR;
            nxt.err   = ERR_SYNTAX;
          end else begin
            nxt.val_off = here;
            nxt.val_cnt = 16'd1;
            nxt.phase   = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (data_byte_i == ChCr) begin
            nxt.phase = PH_CR;
          end else if (ctl_char(data_byte_i) && data_byte_i != ChTab) begin
            nxt.phase = PH_ERR;
            nxt.err   = ERR_SYNTAX;
          end else begin
            nxt.val_cnt = cur.val_cnt + 16'd1;
          end
        end
        PH_CR: begin
          if (data_byte_i != ChLf) begin
            nxt.phase = PH_ERR;
            nxt.err   = ERR_SYNTAX;
          end else if (cur.lines >= max_header_count_i) begin
            nxt.phase = PH_ERR;
            nxt.err   = ERR_LARGE;
          end else begin
            res.record_valid       = 1'b1;
            res.record_index       = cur.lines;
            res.field_name_start   = cur.name_off;
            res.field_name_length  = cur.name_cnt;
            res.field_value_start  = cur.val_off;
            res.field_value_length = cur.val_cnt;
            nxt.lines    = cur.lines + 8'd1;
            nxt.name_cnt = '0;
            nxt.val_cnt  = '0;
            nxt.phase    = PH_EOL;
          end
        end
        PH_EOL: begin
          if (data_byte_i == ChCr) begin
            nxt.phase = PH_CR2;
          end else if (!tok_char(data_byte_i)) begin
            nxt.phase = PH_ERR;
            nxt.err   = ERR_SYNTAX;
          end else begin
            nxt.name_off = here;
            nxt.name_cnt = 16'd1;
            nxt.phase    = PH_NAME;
          end
        end
        PH_CR2: begin
          if (data_byte_i == ChLf) begin
            nxt.phase = PH_DONE;
          end else begin
            nxt.phase = PH_ERR;
            nxt.err   = ERR_SYNTAX;
          end
        end
        default: begin
          nxt.phase = PH_ERR;
          nxt.err   = ERR_SYNTAX;
        end
      endcase
    end

    res.status = (nxt.phase == PH_DONE) ? ST_COMPLETE :
                 (nxt.phase == PH_ERR)  ? ST_ERROR : ST_MORE;
    res.error_kind = nxt.err;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// ===== sv/http_header_block_parser.sv =====
// HTTP/1 header block parser top level: stream ports, config registers, pipeline.
// Depends on hbp_pkg and hbp_step.
// Path: an accepted request is registered in the input stage, then hbp_step computes
// its result into the output stage. Throughput: one byte per cycle while m_axis_tready
// holds: the state register loops through hbp_step combinationally, so requests flow gap-free.
// Reset (rst_ni low, async): input/output stages empty, parser state cleared, limit
// registers back to 16384 bytes and 64 header lines.
module http_header_block_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  hbp_pkg::reg_idx_e            cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  // byte stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tuser,  // [0] start_block
  // result stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status, [3:2] error_kind, [4] byte_ignored, [5] record_valid,
  // [13:6] record_index, [29:14] field_name_start, [45:30] field_name_length,
  // [61:46] field_value_start, [77:62] field_value_length, [79:78] zero
  output logic [hbp_pkg::OutDataW-1:0] m_axis_tdata
);
  import hbp_pkg::*;

  // limit registers
  logic [PosW-1:0]  max_bytes_q;
  logic [LineW-1:0] max_lines_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBlockBytesRst;
      max_lines_q <= MaxHeaderCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_BLOCK_BYTES:  max_bytes_q <= cfg_wdata_i;
        REG_MAX_HEADER_COUNT: max_lines_q <= cfg_wdata_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       advance;
  logic       in_take;

  // output register stage
  logic    out_vld_q;
  result_t out_res_q;

  // parser state: updated only when a byte moves into the output stage
  state_t  state_q;
  state_t  state_d;
  result_t res_d;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  hbp_step u_step (
    .state_i            (state_q),
    .data_byte_i        (in_byte_q),
    .start_block_i      (in_start_q),
    .max_block_bytes_i  (max_bytes_q),
    .max_header_count_i (max_lines_q),
    .state_o            (state_d),
    .result_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_res_q};

  // error phase and a latched error code always go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_ERR) == (state_q.err != ERR_NONE))
    else $error("parser error phase and error code disagree");

  // a header record only comes from a live parse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.record_valid) |->
      (out_res_q.status == ST_MORE && !out_res_q.byte_ignored))
    else $error("record emitted on a finished or ignored byte");

  // dropped bytes only after completion or error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.byte_ignored) |-> (out_res_q.status != ST_MORE))
    else $error("byte ignored while parse still open");

  // byte counter only moves when a byte is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance) |-> $stable(state_q.pos))
    else $error("byte position changed without a byte");

endmodule
